/* design/image_zone_haptic_averager_core_macros.svh */
// Assertion macros for the image zone haptic averager
`ifndef IMAGE_ZONE_HAPTIC_AVERAGER_CORE_MACROS_SVH
`define IMAGE_ZONE_HAPTIC_AVERAGER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define IZHA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define IZHA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define IZHA_ASSERT(lbl, prop, msg)
`define IZHA_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

/* design/izha_pkg.sv */
// Types, constants and zone geometry for the image zone haptic averager
package izha_pkg;

  localparam int MAX_FRAMES_DEF = 16;
  localparam int IMAGE_WIDTH    = 15;
  localparam int IMAGE_ROWS     = 13;
  localparam int ZONE_COUNT     = 12;

  localparam logic [6:0] CLAMP_LIMIT  = 7'd127;
  localparam logic [7:0] AGE_LIMIT    = 8'd255;
  localparam logic [7:0] WINDOW_RESET = 8'd100;

  // reciprocals for the two zone sizes, exact for 12-bit sums
  localparam logic [15:0] RECIP_15    = 16'd34953;
  localparam logic [15:0] RECIP_12    = 16'd43691;
  localparam int          RECIP_SHIFT = 19;

  localparam logic [7:0] HDR_REPORT = 8'd0;
  localparam logic [7:0] HDR_SUPPLY = 8'd1;

  typedef enum logic [1:0] {
    OP_PIXEL  = 2'd0,
    OP_TICK   = 2'd1,
    OP_REPORT = 2'd2,
    OP_SUPPLY = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    REG_ENABLE = 2'd0,
    REG_WINDOW = 2'd1
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIN,
    ST_TK_RD,
    ST_TK_WR,
    ST_EX_RD,
    ST_EX_CHK,
    ST_ZINIT,
    ST_AV_RD,
    ST_AV_ACC,
    ST_DIV,
    ST_ZONE_END,
    ST_DECIDE,
    ST_EMIT
  } state_e;

  // {row_lo, col_lo, row_hi, col_hi}, inclusive
  localparam logic [15:0] ZONE_BOX [ZONE_COUNT] = '{
    {4'd0,  4'd3,  4'd2,  4'd7},  {4'd3,  4'd3,  4'd5,  4'd7},
    {4'd5,  4'd3,  4'd7,  4'd7},  {4'd7,  4'd3,  4'd9,  4'd7},
    {4'd10, 4'd3,  4'd12, 4'd7},  {4'd10, 4'd0,  4'd12, 4'd3},
    {4'd0,  4'd7,  4'd2,  4'd11}, {4'd3,  4'd7,  4'd5,  4'd11},
    {4'd5,  4'd7,  4'd7,  4'd11}, {4'd7,  4'd7,  4'd9,  4'd11},
    {4'd10, 4'd7,  4'd12, 4'd11}, {4'd10, 4'd11, 4'd12, 4'd14}
  };

  function automatic logic zone_hit(input int z, input logic [3:0] row,
                                    input logic [3:0] col);
    logic [15:0] b;
    b = ZONE_BOX[z];
    return (row >= b[15:12]) && (row <= b[7:4]) && (col >= b[11:8]) && (col <= b[3:0]);
  endfunction

  // zone mean: sum divided by the zone's pixel count (15, or 12 for the corner zones)
  function automatic logic [6:0] zone_mean(input logic [3:0] z, input logic [11:0] sum);
    logic [15:0] recip;
    logic [27:0] prod;
    recip = ((z == 4'd5) || (z == 4'd11)) ? RECIP_12 : RECIP_15;
    prod  = 28'(sum) * 28'(recip);
    return prod[RECIP_SHIFT+6:RECIP_SHIFT];
  endfunction

endpackage

/* design/image_zone_haptic_averager_core.sv */
// Image zone haptic averager: one item per pixel, tick, report or supply reset.
// Every item is taken from idle. The last pixel of a frame then writes the zone means
// into the frame memory, one write per zone (no writes when recording is off). A tick then
// reads and then writes the age memory for each slot. A supply reset then loads its byte
// into the output register. A report first reads and checks the age of the oldest kept
// frame, dropping expired frames until one is within the window (no check once the store is
// empty). Then per zone it sets up, reads each stored frame in turn (one means-memory read
// port) and, when frames remain, divides bit-serially, then wraps up by comparing the mean
// against the last value sent. If any mean differs or none was sent yet, it then sends
// one byte per cycle while the output is not stalled. No new item is taken until the previous
// one is done, but the last byte may wait in the output register meanwhile.
`include "image_zone_haptic_averager_core_macros.svh"
module image_zone_haptic_averager_core #(
  parameter int MAX_FRAMES = izha_pkg::MAX_FRAMES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] operation_i,
  input  logic [6:0] pixel_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       last_byte_o
);

  localparam int ZC = izha_pkg::ZONE_COUNT;
  localparam int SW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CW = $clog2(MAX_FRAMES + 1);
  localparam int TW = 7 + CW;
  localparam int AW = $clog2(MAX_FRAMES * ZC);
  localparam int DW = $clog2(TW + 1);

  izha_pkg::state_e state_q, state_d;

  logic       enable_q;
  logic [7:0] window_q;
  logic [3:0] row_q, col_q;
  logic [11:0] sums_q [ZC];
  logic [SW-1:0] head_q, slot_q, tk_idx_q;
  logic [CW-1:0] count_q, k_q;
  logic [3:0] z_q, emit_q;
  logic [TW-1:0] total_q, quo_q;
  logic [CW-1:0] rem_q;
  logic [DW-1:0] step_q;
  logic [6:0] avg_q [ZC];
  logic [6:0] sent_q [ZC];
  logic sent_once_q, differ_q, supply_q;
  logic out_valid_q, last_q;
  logic [7:0] out_byte_q;

  // memories
  logic [6:0] means_mem [MAX_FRAMES*ZC];
  logic [7:0] ages_mem [MAX_FRAMES];
  logic [6:0] means_rd_q;
  logic [7:0] ages_rd_q;
  logic [AW-1:0] means_raddr, means_waddr;
  logic means_we;
  logic [6:0] means_wdata;
  logic [SW-1:0] ages_raddr, ages_waddr;
  logic ages_we;
  logic [7:0] ages_wdata;

  logic in_acc, out_free, last_pixel;
  logic [SW-1:0] oldest, head_next, slot_next;
  logic [CW:0] head_ext, cnt_ext;
  logic [CW:0] div_t;
  logic [6:0] avg_now;
  logic [TW-1:0] acc_sum;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign last_pixel = (row_q == 4'(izha_pkg::IMAGE_ROWS - 1))
                   && (col_q == 4'(izha_pkg::IMAGE_WIDTH - 1));

  assign head_ext = (CW+1)'(head_q);
  assign cnt_ext  = (CW+1)'(count_q);
  always_comb begin
    if (head_ext >= cnt_ext) oldest = SW'(head_ext - cnt_ext);
    else oldest = SW'(head_ext + (CW+1)'(MAX_FRAMES) - cnt_ext);
  end
  assign head_next = (head_q == SW'(MAX_FRAMES - 1)) ? '0 : head_q + SW'(1);
  assign slot_next = (slot_q == SW'(MAX_FRAMES - 1)) ? '0 : slot_q + SW'(1);
  assign div_t     = {rem_q, quo_q[TW-1]};
  assign acc_sum   = total_q + TW'(means_rd_q);
  assign avg_now   = (quo_q > TW'(izha_pkg::CLAMP_LIMIT)) ? izha_pkg::CLAMP_LIMIT : quo_q[6:0];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      izha_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (operation_i)
            izha_pkg::OP_PIXEL:  if (last_pixel) state_d = izha_pkg::ST_FIN;
            izha_pkg::OP_TICK:   state_d = izha_pkg::ST_TK_RD;
            izha_pkg::OP_REPORT: state_d = izha_pkg::ST_EX_RD;
            default:             state_d = izha_pkg::ST_EMIT;
          endcase
        end
      end
      izha_pkg::ST_FIN:
        if (!enable_q || z_q == 4'(ZC - 1)) state_d = izha_pkg::ST_IDLE;
      izha_pkg::ST_TK_RD: state_d = izha_pkg::ST_TK_WR;
      izha_pkg::ST_TK_WR:
        if (tk_idx_q == SW'(MAX_FRAMES - 1)) state_d = izha_pkg::ST_IDLE;
        else state_d = izha_pkg::ST_TK_RD;
      izha_pkg::ST_EX_RD:
        state_d = (count_q == '0) ? izha_pkg::ST_ZINIT : izha_pkg::ST_EX_CHK;
      izha_pkg::ST_EX_CHK:
        state_d = (ages_rd_q > window_q) ? izha_pkg::ST_EX_RD : izha_pkg::ST_ZINIT;
      izha_pkg::ST_ZINIT:
        state_d = (count_q == '0) ? izha_pkg::ST_ZONE_END : izha_pkg::ST_AV_RD;
      izha_pkg::ST_AV_RD: state_d = izha_pkg::ST_AV_ACC;
      izha_pkg::ST_AV_ACC:
        state_d = (k_q + CW'(1) == count_q) ? izha_pkg::ST_DIV : izha_pkg::ST_AV_RD;
      izha_pkg::ST_DIV:
        if (step_q == DW'(TW - 1)) state_d = izha_pkg::ST_ZONE_END;
      izha_pkg::ST_ZONE_END:
        state_d = (z_q == 4'(ZC - 1)) ? izha_pkg::ST_DECIDE : izha_pkg::ST_ZINIT;
      izha_pkg::ST_DECIDE:
        state_d = (differ_q || !sent_once_q) ? izha_pkg::ST_EMIT : izha_pkg::ST_IDLE;
      izha_pkg::ST_EMIT:
        if (out_free && (supply_q || emit_q == 4'(ZC))) state_d = izha_pkg::ST_IDLE;
      default: state_d = izha_pkg::ST_IDLE;
    endcase
  end

  // memory ports and handshake
  always_comb begin
    in_stall_o  = (state_q != izha_pkg::ST_IDLE);
    means_we    = 1'b0;
    means_waddr = AW'(head_q) * AW'(ZC) + AW'(z_q);
    means_wdata = izha_pkg::zone_mean(z_q, sums_q[z_q]);
    means_raddr = AW'(slot_q) * AW'(ZC) + AW'(z_q);
    ages_we     = 1'b0;
    ages_waddr  = tk_idx_q;
    ages_wdata  = (ages_rd_q == izha_pkg::AGE_LIMIT) ? ages_rd_q : ages_rd_q + 8'd1;
    ages_raddr  = tk_idx_q;
    unique case (state_q)
      izha_pkg::ST_FIN: begin
        means_we = enable_q;
        if (enable_q && z_q == 4'(ZC - 1)) begin
          ages_we    = 1'b1;
          ages_waddr = head_q;
          ages_wdata = 8'd0;
        end
      end
      izha_pkg::ST_TK_WR: ages_we = 1'b1;
      izha_pkg::ST_EX_RD: ages_raddr = oldest;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (means_we) means_mem[means_waddr] <= means_wdata;
    means_rd_q <= means_mem[means_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (ages_we) ages_mem[ages_waddr] <= ages_wdata;
    ages_rd_q <= ages_mem[ages_raddr];
  end

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b1;
      window_q <= izha_pkg::WINDOW_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        izha_pkg::REG_ENABLE: enable_q <= cfg_data_i[0];
        izha_pkg::REG_WINDOW: window_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= izha_pkg::ST_IDLE;
      row_q       <= '0;
      col_q       <= '0;
      head_q      <= '0;
      count_q     <= '0;
      sent_once_q <= 1'b0;
      out_valid_q <= 1'b0;
      z_q         <= '0;
      emit_q      <= '0;
      supply_q    <= 1'b0;
      differ_q    <= 1'b0;
      tk_idx_q    <= '0;
      k_q         <= '0;
      step_q      <= '0;
      for (int i = 0; i < ZC; i++) begin
        sums_q[i] <= '0;
        sent_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= (state_q == izha_pkg::ST_EMIT && out_free) || (out_valid_q && out_stall_i);
      unique case (state_q)
        izha_pkg::ST_IDLE: begin
          if (in_acc) begin
            z_q      <= '0;
            emit_q   <= '0;
            tk_idx_q <= '0;
            differ_q <= 1'b0;
            supply_q <= (operation_i == izha_pkg::OP_SUPPLY);
            if (operation_i == izha_pkg::OP_PIXEL) begin
              for (int i = 0; i < ZC; i++)
                if (izha_pkg::zone_hit(i, row_q, col_q))
                  sums_q[i] <= sums_q[i] + 12'(pixel_i);
              if (last_pixel) begin
                row_q <= '0;
                col_q <= '0;
              end else if (col_q == 4'(izha_pkg::IMAGE_WIDTH - 1)) begin
                col_q <= '0;
                row_q <= row_q + 4'd1;
              end else begin
                col_q <= col_q + 4'd1;
              end
            end
          end
        end
        izha_pkg::ST_FIN: begin
          z_q <= z_q + 4'd1;
          if (!enable_q || z_q == 4'(ZC - 1)) begin
            for (int i = 0; i < ZC; i++) sums_q[i] <= '0;
            if (enable_q) begin
              head_q <= head_next;
              if (count_q != CW'(MAX_FRAMES)) count_q <= count_q + CW'(1);
            end
          end
        end
        izha_pkg::ST_TK_WR: tk_idx_q <= tk_idx_q + SW'(1);
        izha_pkg::ST_EX_CHK: if (ages_rd_q > window_q) count_q <= count_q - CW'(1);
        izha_pkg::ST_ZINIT: begin
          total_q <= '0;
          quo_q   <= '0;
          k_q     <= '0;
          slot_q  <= oldest;
        end
        izha_pkg::ST_AV_ACC: begin
          total_q <= acc_sum;
          k_q     <= k_q + CW'(1);
          slot_q  <= slot_next;
          quo_q   <= acc_sum;
          rem_q   <= '0;
          step_q  <= '0;
        end
        izha_pkg::ST_DIV: begin
          step_q <= step_q + DW'(1);
          if (div_t >= cnt_ext) begin
            rem_q <= CW'(div_t - cnt_ext);
            quo_q <= {quo_q[TW-2:0], 1'b1};
          end else begin
            rem_q <= div_t[CW-1:0];
            quo_q <= {quo_q[TW-2:0], 1'b0};
          end
        end
        izha_pkg::ST_ZONE_END: begin
          avg_q[z_q] <= avg_now;
          if (avg_now != sent_q[z_q]) differ_q <= 1'b1;
          z_q <= z_q + 4'd1;
        end
        izha_pkg::ST_DECIDE: begin
          if (differ_q || !sent_once_q) begin
            sent_once_q <= 1'b1;
            for (int i = 0; i < ZC; i++) sent_q[i] <= avg_q[i];
          end
        end
        izha_pkg::ST_EMIT: begin
          if (out_free) emit_q <= emit_q + 4'd1;
        end
        default: ;
      endcase
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (state_q == izha_pkg::ST_EMIT && out_free) begin
      if (supply_q) begin
        out_byte_q <= izha_pkg::HDR_SUPPLY;
        last_q     <= 1'b1;
      end else if (emit_q == 4'd0) begin
        out_byte_q <= izha_pkg::HDR_REPORT;
        last_q     <= 1'b0;
      end else begin
        out_byte_q <= 8'(avg_q[emit_q - 4'd1]);
        last_q     <= (emit_q == 4'(ZC));
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign last_byte_o = last_q;

  `IZHA_ASSERT(a_count_bound, count_q <= CW'(MAX_FRAMES), "frame count above store depth")
  `IZHA_ASSERT(a_pos_range, (row_q < 4'(izha_pkg::IMAGE_ROWS)) && (col_q < 4'(izha_pkg::IMAGE_WIDTH)), "pixel position out of frame")
  `IZHA_ASSERT(a_emit_bound, emit_q <= 4'(ZC + 1), "emit counter overrun")
  `IZHA_ASSERT(a_fresh_frame, (state_q == izha_pkg::ST_IDLE && row_q == 4'd0 && col_q == 4'd0) |-> (sums_q[0] == '0 && sums_q[11] == '0), "zone sums not cleared at frame start")

endmodule
